// File: rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming substring find-and-replace.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Text bytes held for one burst of results (replacement or flush)
  localparam int BURST_DEPTH = 16;
  // Width of length fields and counters that reach BURST_DEPTH
  localparam int LEN_W = 5;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int TOTAL_W = 32;
  localparam int MAX_PATTERN_DEF = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEN = 3'd0,
    REG_PAT_LO  = 3'd1,
    REG_PAT_HI  = 3'd2,
    REG_REP_LEN = 3'd3,
    REG_REP_LO  = 3'd4,
    REG_REP_HI  = 3'd5
  } sfr_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               string_end;
    logic [TOTAL_W-1:0] match_total;
  } sfr_out_t;

endpackage

// File: rtl/core/substring_find_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_find_replace
// Streaming find-and-replace: a window of pending bytes is compared against
// the pattern and matches are rewritten with the replacement text.
// ----------------------------------------------------------------------------
// Result path: an accepted transaction is held in the input register and
//   is loaded into the result burst register once that register is free.
// Throughput: one byte per cycle while each byte yields at most one result
//   and the output is not stalled; a byte that yields several results
//   (replacement or end flush) holds the input while the burst register
//   drains one result per take.
// Reset: all configuration, window fill and match count clear to zero.
module substring_find_replace
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfr_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfr_out_t             out_data_o
);

  localparam int WIN_DEPTH = (MAX_PATTERN < BURST_DEPTH) ? MAX_PATTERN : BURST_DEPTH;
  localparam int WIDX_W = $clog2(WIN_DEPTH);
  localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(WIN_DEPTH);
  localparam logic [LEN_W-1:0] BURST_LEN = LEN_W'(BURST_DEPTH);

  // Configuration registers
  logic [LEN_W-1:0] pat_len_q, rep_len_q;
  logic [CFG_W-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;

  // Input register
  logic    in_vld_q;
  sfr_in_t in_q;

  // Window state
  logic [7:0]         win_q [WIN_DEPTH];
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic [TOTAL_W-1:0] count_q, count_d;

  // Result burst register
  logic [7:0]         burst_q [BURST_DEPTH];
  logic [7:0]         burst_d [BURST_DEPTH];
  logic [LEN_W-1:0]   bcnt_q, bcnt_d;
  logic               bval_q, bval_d;
  logic               bend_q, bend_d;
  logic [TOTAL_W-1:0] btot_q;

  // Combinational working signals
  logic [7:0]         win_w [WIN_DEPTH];
  logic [7:0]         win_d [WIN_DEPTH];
  logic [2*CFG_W-1:0] pat_vec, rep_vec;
  logic [LEN_W-1:0]   plen, rlen, fe, nf;
  logic               hit, advance, out_take, in_take;

  assign pat_vec = {pat_hi_q, pat_lo_q};
  assign rep_vec = {rep_hi_q, rep_lo_q};
  assign plen = (pat_len_q > WIN_LEN) ? WIN_LEN : pat_len_q;
  assign rlen = (rep_len_q > BURST_LEN) ? BURST_LEN : rep_len_q;

  // Handshakes
  assign out_valid_o = (bcnt_q != '0);
  assign out_take = out_valid_o & ~out_stall_i;
  assign advance = in_vld_q & ((bcnt_q == '0) | ((bcnt_q == LEN_W'(1)) & ~out_stall_i));
  assign in_stall_o = in_vld_q & ~advance;
  assign in_take = in_valid_i & ~in_stall_o;

  assign out_data_o.out_byte    = burst_q[0];
  assign out_data_o.byte_valid  = bval_q;
  assign out_data_o.string_end  = bend_q & (bcnt_q == LEN_W'(1));
  assign out_data_o.match_total = btot_q;

  // Window update, match check and burst build for the held transaction
  always_comb begin
    fe = (fill_q >= plen && plen != '0) ? plen - LEN_W'(1) : fill_q;
    nf = fe + LEN_W'(1);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_w[i] = win_q[i];
    end
    win_w[fe[WIDX_W-1:0]] = in_q.data_byte;

    hit = (nf == plen);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (LEN_W'(i) < plen && win_w[i] != pat_vec[8*i +: 8]) begin
        hit = 1'b0;
      end
    end

    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_d[i] = win_w[i];
    end
    for (int i = 0; i < BURST_DEPTH; i++) begin
      burst_d[i] = 8'h00;
    end
    fill_d = fill_q;
    count_d = count_q;
    bcnt_d = '0;
    bval_d = 1'b1;
    bend_d = in_q.final_byte;

    if (plen == '0) begin
      // Pass-through
      fill_d = '0;
      burst_d[0] = in_q.data_byte;
      bcnt_d = LEN_W'(1);
    end else if (hit) begin
      if (count_q != '1) begin
        count_d = count_q + TOTAL_W'(1);
      end
      for (int i = 0; i < BURST_DEPTH; i++) begin
        burst_d[i] = rep_vec[8*i +: 8];
      end
      bcnt_d = rlen;
      fill_d = '0;
    end else if (in_q.final_byte) begin
      // Flush pending bytes at string end
      for (int i = 0; i < WIN_DEPTH; i++) begin
        burst_d[i] = win_w[i];
      end
      bcnt_d = nf;
      fill_d = '0;
    end else if (nf == plen) begin
      // Full without a match: emit oldest byte and slide
      burst_d[0] = win_w[0];
      bcnt_d = LEN_W'(1);
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_d[i] = win_w[i+1];
      end
      fill_d = plen - LEN_W'(1);
    end else begin
      fill_d = nf;
    end

    // End marker when the last byte yields no data
    if (in_q.final_byte && bcnt_d == '0) begin
      burst_d[0] = 8'h00;
      bcnt_d = LEN_W'(1);
      bval_d = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      rep_len_q <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT_LEN: begin
          if (fill_q == '0) begin
            pat_len_q <= cfg_data_i[LEN_W-1:0];
          end
        end
        REG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        REG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        REG_REP_LEN: rep_len_q <= cfg_data_i[LEN_W-1:0];
        REG_REP_LO:  rep_lo_q  <= cfg_data_i;
        REG_REP_HI:  rep_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Window storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // Fill level and match counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
    end else if (advance) begin
      fill_q  <= in_q.final_byte ? '0 : fill_d;
      count_q <= in_q.final_byte ? '0 : count_d;
    end
  end

  // Burst register: load on advance, shift out one result per take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
    end else if (advance) begin
      bcnt_q <= bcnt_d;
    end else if (out_take) begin
      bcnt_q <= bcnt_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < BURST_DEPTH; i++) begin
        burst_q[i] <= burst_d[i];
      end
      bval_q <= bval_d;
      bend_q <= bend_d;
      btot_q <= count_d;
    end else if (out_take) begin
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        burst_q[i] <= burst_q[i+1];
      end
    end
  end

  // Assertions
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= BURST_LEN)
    else $error("burst count exceeds burst depth");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) || (fill_q < plen))
    else $error("window fill not below pattern length");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.final_byte |=> (fill_q == '0) && (count_q == '0))
    else $error("string end did not clear window and count");

  a_marker_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.string_end)
    else $error("end marker without string end");

  a_free_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && (bcnt_q == '0) |-> !in_stall_o)
    else $error("held transaction stalled with empty burst register");

endmodule
